[hdl/pc_pkg.sv]
// Shared types and constants of the Pearson correlation block.
package pc_pkg;

	// Sample width of the x and y ports
	localparam int SAMPLE_W = 16;

	// Quotient search: result magnitude in Q1.15, found one bit per trial
	localparam int Q_W      = 16;
	localparam int BIT_W    = 4;
	localparam int K_W      = 32;
	localparam int RHS_SHIFT = 32;
	localparam logic [Q_W-1:0]   Q_LIMIT  = 16'h8000;
	localparam logic [Q_W-1:0]   CORR_MAX = 16'h7fff;
	localparam logic [BIT_W-1:0] TOP_BIT  = 4'd15;

	// Multiply operations run on the shared multiplier, in sequence order
	typedef enum logic [3:0] {
		OP_NSXY,
		OP_SXSY,
		OP_NSXX,
		OP_SXSX,
		OP_NSYY,
		OP_SYSY,
		OP_D,
		OP_NUM2,
		OP_LHS
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDEF = 2'd1,
		ST_OVF   = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              mul_start;
		op_t               op;
		logic              store;
		logic              q_init;
		logic              k_load;
		logic              out_load;
		status_t           status;
		logic [BIT_W-1:0]  bit_idx;
	} pc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mul_done;
		logic overflow;
		logic var_bad;
		logic trial_over;
		logic out_free;
	} pc_sts_t;

endpackage

[hdl/pc_mul.sv]
// Shift-add unsigned multiplier, one multiplier bit per cycle.
module pc_mul #(
	parameter int AW = 118,
	parameter int BW = 59,
	parameter int RW = 150
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [RW-1:0] p
);

	logic          busy_q;
	logic [RW-1:0] acc_q;
	logic [RW-1:0] a_q;
	logic [BW-1:0] b_q;

	// Control: busy until the multiplier runs out of set bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	// Partial product accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= RW'(a);
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[RW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign done = busy_q && (b_q == '0);
	assign p    = acc_q;

endmodule

[hdl/pc_datapath.sv]
// Datapath: sum accumulators, centered terms, quotient search and result register.
module pc_datapath #(
	parameter int MAX_LEN = 4096,
	parameter int CW      = 13
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_take,
	input  logic [pc_pkg::SAMPLE_W-1:0]    x_value,
	input  logic [pc_pkg::SAMPLE_W-1:0]    y_value,
	input  pc_pkg::pc_cmd_t                cmd,
	output pc_pkg::pc_sts_t                sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    correlation,
	output logic [1:0]                     status,
	output logic [CW-1:0]                  pair_count
);

	localparam int W  = pc_pkg::SAMPLE_W;
	localparam int SW = W + CW;
	localparam int PW = 2 * W + CW;
	localparam int VW = 2 * W + 2 * CW + 1;
	localparam int VS = VW + 1;
	localparam int AW = 2 * VW;
	localparam int BW = VW;
	localparam int RW = 2 * VW + pc_pkg::K_W;
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

	// Stage 1: sample products
	logic                 take_s1;
	logic signed [W-1:0]  x_s1, y_s1;
	logic signed [2*W-1:0] xy_s1, xx_s1, yy_s1;

	// Running sums and count
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic signed [SW-1:0] sx_q, sy_q;
	logic signed [PW-1:0] sxy_q, sxx_q, syy_q;

	// Final computation registers
	logic signed [VS-1:0] t1_q, num_q, vx_q, vy_q;
	logic [2*VW-1:0]      d_q;
	logic [RW-1:0]        rhs_q;
	logic [pc_pkg::K_W-1:0] k_q;
	logic [pc_pkg::Q_W-1:0] q_q;

	logic                 out_valid_q;
	logic [15:0]          corr_q;
	logic [1:0]           status_q;
	logic [CW-1:0]        count_q;

	// Multiplier interface
	logic [AW-1:0]        mul_a;
	logic [BW-1:0]        mul_b;
	logic                 mul_done;
	logic [RW-1:0]        mul_p;
	logic signed [VS-1:0] prod_v;

	logic [SW-1:0]        sx_mag, sy_mag;
	logic [PW-1:0]        sxy_mag, sxx_mag, syy_mag;
	logic [VS-1:0]        num_abs;
	logic [pc_pkg::Q_W-1:0] trial;
	logic [pc_pkg::Q_W:0] odd_w;
	logic [15:0]          corr_d;

	// Product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
		end else begin
			take_s1 <= in_take && (cnt_q < LEN_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_s1  <= $signed(x_value);
			y_s1  <= $signed(y_value);
			xy_s1 <= $signed(x_value) * $signed(y_value);
			xx_s1 <= $signed(x_value) * $signed(x_value);
			yy_s1 <= $signed(y_value) * $signed(y_value);
		end
	end

	// Count, overflow flag and sums; cleared when a result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
			syy_q <= '0;
		end else if (cmd.out_load) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
			syy_q <= '0;
		end else begin
			if (in_take) begin
				if (cnt_q < LEN_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (take_s1) begin
				sx_q  <= sx_q + {{CW{x_s1[W-1]}}, x_s1};
				sy_q  <= sy_q + {{CW{y_s1[W-1]}}, y_s1};
				sxy_q <= sxy_q + {{CW{xy_s1[2*W-1]}}, xy_s1};
				sxx_q <= sxx_q + {{CW{xx_s1[2*W-1]}}, xx_s1};
				syy_q <= syy_q + {{CW{yy_s1[2*W-1]}}, yy_s1};
			end
		end
	end

	// Magnitudes of the sums
	assign sx_mag  = sx_q[SW-1]  ? SW'(-sx_q)  : SW'(sx_q);
	assign sy_mag  = sy_q[SW-1]  ? SW'(-sy_q)  : SW'(sy_q);
	assign sxy_mag = sxy_q[PW-1] ? PW'(-sxy_q) : PW'(sxy_q);
	assign sxx_mag = sxx_q[PW-1] ? PW'(-sxx_q) : PW'(sxx_q);
	assign syy_mag = syy_q[PW-1] ? PW'(-syy_q) : PW'(syy_q);
	assign num_abs = num_q[VS-1] ? VS'(-num_q) : VS'(num_q);

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pc_pkg::OP_NSXY: begin
				mul_a = AW'(sxy_mag);
				mul_b = BW'(cnt_q);
			end
			pc_pkg::OP_SXSY: begin
				mul_a = AW'(sx_mag);
				mul_b = BW'(sy_mag);
			end
			pc_pkg::OP_NSXX: begin
				mul_a = AW'(sxx_mag);
				mul_b = BW'(cnt_q);
			end
			pc_pkg::OP_SXSX: begin
				mul_a = AW'(sx_mag);
				mul_b = BW'(sx_mag);
			end
			pc_pkg::OP_NSYY: begin
				mul_a = AW'(syy_mag);
				mul_b = BW'(cnt_q);
			end
			pc_pkg::OP_SYSY: begin
				mul_a = AW'(sy_mag);
				mul_b = BW'(sy_mag);
			end
			pc_pkg::OP_D: begin
				mul_a = AW'(vx_q[VW-1:0]);
				mul_b = vy_q[VW-1:0];
			end
			pc_pkg::OP_NUM2: begin
				mul_a = AW'(num_abs[VW-1:0]);
				mul_b = num_abs[VW-1:0];
			end
			pc_pkg::OP_LHS: begin
				mul_a = d_q;
				mul_b = BW'(k_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pc_mul #(
		.AW (AW),
		.BW (BW),
		.RW (RW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign prod_v = $signed(VS'(mul_p));

	// Trial quotient and its odd value 2t-1, squared into k_q on k_load
	assign trial = q_q | (pc_pkg::Q_W'(1) << cmd.bit_idx);
	assign odd_w = {trial, 1'b0} - 1'b1;

	// Result staging from the product
	always_ff @(posedge clk) begin
		if (cmd.q_init) begin
			q_q <= '0;
		end
		if (cmd.k_load) begin
			k_q <= pc_pkg::K_W'(odd_w) * pc_pkg::K_W'(odd_w);
		end
		if (cmd.store) begin
			case (cmd.op)
				pc_pkg::OP_NSXY: t1_q <= sxy_q[PW-1] ? -prod_v : prod_v;
				pc_pkg::OP_SXSY: num_q <= t1_q - ((sx_q[SW-1] ^ sy_q[SW-1]) ? -prod_v : prod_v);
				pc_pkg::OP_NSXX: t1_q <= sxx_q[PW-1] ? -prod_v : prod_v;
				pc_pkg::OP_SXSX: vx_q <= t1_q - prod_v;
				pc_pkg::OP_NSYY: t1_q <= syy_q[PW-1] ? -prod_v : prod_v;
				pc_pkg::OP_SYSY: vy_q <= t1_q - prod_v;
				pc_pkg::OP_D:    d_q <= mul_p[2*VW-1:0];
				pc_pkg::OP_NUM2: rhs_q <= {mul_p[2*VW-1:0], {pc_pkg::RHS_SHIFT{1'b0}}};
				pc_pkg::OP_LHS: begin
					if (mul_p <= rhs_q) begin
						q_q <= trial;
					end
				end
				default: t1_q <= t1_q;
			endcase
		end
	end

	// Signed, clamped coefficient; zero when the status is not ok
	always_comb begin
		if (cmd.status != pc_pkg::ST_OK) begin
			corr_d = '0;
		end else if (num_q[VS-1]) begin
			corr_d = -q_q;
		end else if (q_q > pc_pkg::CORR_MAX) begin
			corr_d = pc_pkg::CORR_MAX;
		end else begin
			corr_d = q_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			corr_q   <= corr_d;
			status_q <= cmd.status;
			count_q  <= cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign correlation = corr_q;
	assign status      = status_q;
	assign pair_count  = count_q;

	assign sts.mul_done   = mul_done;
	assign sts.overflow   = ovf_q;
	assign sts.var_bad    = vx_q[VS-1] || (vx_q == '0) || vy_q[VS-1] || (vy_q == '0);
	assign sts.trial_over = trial > pc_pkg::Q_LIMIT;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

[hdl/pc_ctrl.sv]
// Controller: sequences accumulation, multiplies, quotient search and result load.
module pc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last,
	output logic            in_ready,
	output logic            in_take,
	input  pc_pkg::pc_sts_t sts,
	output pc_pkg::pc_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DRAIN,
		S_DECIDE,
		S_MSTART,
		S_MWAIT,
		S_CHKVAR,
		S_KCALC,
		S_TNEXT,
		S_FINISH
	} state_t;

	state_t                      state_q;
	pc_pkg::op_t                 op_q;
	logic [pc_pkg::BIT_W-1:0]    bit_q;
	pc_pkg::status_t             status_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_take  = in_valid && in_ready;

	// State and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= pc_pkg::OP_NSXY;
			bit_q    <= '0;
			status_q <= pc_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take && last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.overflow) begin
						status_q <= pc_pkg::ST_OVF;
						state_q  <= S_FINISH;
					end else begin
						status_q <= pc_pkg::ST_OK;
						op_q     <= pc_pkg::OP_NSXY;
						state_q  <= S_MSTART;
					end
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.mul_done) begin
						case (op_q)
							pc_pkg::OP_SYSY: state_q <= S_CHKVAR;
							pc_pkg::OP_NUM2: begin
								bit_q   <= pc_pkg::TOP_BIT;
								state_q <= S_KCALC;
							end
							pc_pkg::OP_LHS: state_q <= S_TNEXT;
							default: begin
								op_q    <= pc_pkg::op_t'(op_q + 1'b1);
								state_q <= S_MSTART;
							end
						endcase
					end
				end
				S_CHKVAR: begin
					if (sts.var_bad) begin
						status_q <= pc_pkg::ST_UNDEF;
						state_q  <= S_FINISH;
					end else begin
						op_q    <= pc_pkg::OP_D;
						state_q <= S_MSTART;
					end
				end
				S_KCALC: begin
					if (sts.trial_over) begin
						state_q <= S_TNEXT;
					end else begin
						op_q    <= pc_pkg::OP_LHS;
						state_q <= S_MSTART;
					end
				end
				S_TNEXT: begin
					if (bit_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_KCALC;
					end
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands decoded from state
	always_comb begin
		cmd.mul_start = (state_q == S_MSTART);
		cmd.op        = op_q;
		cmd.store     = (state_q == S_MWAIT) && sts.mul_done;
		cmd.q_init    = (state_q == S_DECIDE);
		cmd.k_load    = (state_q == S_KCALC) && !sts.trial_over;
		cmd.out_load  = (state_q == S_FINISH) && sts.out_free;
		cmd.status    = status_q;
		cmd.bit_idx   = bit_q;
	end

endmodule

[hdl/pearson_correlation.sv]
// Pearson correlation top level: controller plus datapath.
//
// Input channel (in_valid/in_ready): one (x_value, y_value) request per
// cycle while the block accumulates; last marks the final pair of a vector.
// Output channel (out_valid/out_ready): one result per vector, carrying
// correlation (signed Q1.15, clamped to 32767), status (0 ok, 1 zero
// variance, 2 more than MAX_LEN pairs) and pair_count.
// Throughput: pairs are taken at one per cycle. After the last pair the
// input stalls while the terms are formed on one shared shift-add
// multiplier: eight long multiplies, whose operands are sized by W sample
// bits and C count bits, and sixteen quotient trials. The multiplier loop
// sets how long a result takes.
// A finished result sits in the output register; accumulation of the next
// vector resumes at once, and only the next result waits if out_ready is
// held low. Reset clears sums, count, flags and the output valid.
module pearson_correlation #(
	parameter int MAX_LEN = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pc_pkg::SAMPLE_W-1:0]       x_value,
	input  logic [pc_pkg::SAMPLE_W-1:0]       y_value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [15:0]                       correlation,
	output logic [1:0]                        status,
	output logic [$clog2(MAX_LEN+1)-1:0]      pair_count
);

	localparam int CW = $clog2(MAX_LEN + 1);

	pc_pkg::pc_cmd_t cmd;
	pc_pkg::pc_sts_t sts;
	logic            in_take;

	pc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.in_take  (in_take),
		.sts      (sts),
		.cmd      (cmd)
	);

	pc_datapath #(
		.MAX_LEN (MAX_LEN),
		.CW      (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.x_value     (x_value),
		.y_value     (y_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.correlation (correlation),
		.status      (status),
		.pair_count  (pair_count)
	);

endmodule
